// ----- design/htsr_pkg.sv -----
// Shared types and constants for the handle table with swap-remove delete.
// No dependencies; used by htsr_cell and handle_table_swap_remove_top.
package htsr_pkg;

    localparam int CAPACITY    = 16;
    localparam int HANDLE_BITS = 48;
    localparam int HANDLE_IN_W = 48;
    localparam int SLOT_W      = 4;
    localparam int COUNT_W_OUT = 5;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } state_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic                   active;
        logic                   del;
        logic [HANDLE_BITS-1:0] handle;
        logic                   hit;
        logic [IDX_W-1:0]       slot;
        logic [HANDLE_BITS-1:0] last;
    } token_t;

    // entry write broadcast to all cells
    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       slot;
        logic [HANDLE_BITS-1:0] data;
    } wr_t;

    // finished request waiting to commit
    typedef struct packed {
        logic                   found;
        logic [IDX_W-1:0]       slot;
        logic [CNT_W-1:0]       cnt;
        logic                   full;
        wr_t                    wr;
    } result_t;

endpackage

// ----- design/handle_table_swap_remove_top.sv -----
// Top level of the handle table: request FSM, result staging and the cell row.
// Depends on htsr_pkg and htsr_cell.
//
// Unordered table of up to CAPACITY (16) handles with add, find and
// swap-remove delete; every request returns one word. An add (or the unused
// request code) is staged at accept and commits in the finish state. A find or
// delete sends a search token down the row of CAPACITY cells, one cell per
// cycle; the lowest matching slot wins, and a delete moves the last entry
// into that slot. Requests are taken one at a time; a finished word waits
// in the output register while the next request is accepted.
module handle_table_swap_remove_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [47:0] handle
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] slot, [8:4] entry_count, [15:9] zero
    output logic [1:0]  m_tuser    // [0] found, [1] table_full
);

    localparam int CAP = htsr_pkg::CAPACITY;

    htsr_pkg::state_t                state_reg, state_next;
    logic [htsr_pkg::CNT_W-1:0]      count_reg;
    htsr_pkg::result_t               fin_reg, fin_next;
    logic                            fin_load;
    logic                            m_valid_reg;
    htsr_pkg::result_t               m_res_reg;
    htsr_pkg::token_t                tok [0:CAP];
    htsr_pkg::wr_t                   wr;
    logic                            accept;
    logic                            out_free;
    logic                            commit;
    logic                            is_search;
    logic [htsr_pkg::HANDLE_BITS-1:0] req_handle;
    htsr_pkg::token_t                tok_end;

    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign is_search  = (s_tuser == htsr_pkg::REQ_FIND) || (s_tuser == htsr_pkg::REQ_DELETE);
    assign req_handle = htsr_pkg::HANDLE_BITS'(s_tdata[htsr_pkg::HANDLE_IN_W-1:0]);
    assign tok_end    = tok[CAP];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            htsr_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = is_search ? htsr_pkg::ST_WALK : htsr_pkg::ST_FIN;
                end
            end
            htsr_pkg::ST_WALK: begin
                if (tok_end.active) begin
                    state_next = htsr_pkg::ST_FIN;
                end
            end
            htsr_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = htsr_pkg::ST_IDLE;
                end
            end
            default: state_next = htsr_pkg::ST_IDLE;
        endcase
    end

    // outputs of the FSM
    always_comb begin
        s_tready = 1'b0;
        commit   = 1'b0;
        fin_load = 1'b0;
        case (state_reg)
            htsr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                fin_load = accept && !is_search;
            end
            htsr_pkg::ST_WALK: fin_load = tok_end.active;
            htsr_pkg::ST_FIN:  commit   = out_free;
            default: ;
        endcase
    end

    // token injected into the first cell
    always_comb begin
        tok[0]        = '0;
        tok[0].active = accept && is_search;
        tok[0].del    = s_tuser == htsr_pkg::REQ_DELETE;
        tok[0].handle = req_handle;
    end

    // staged result for add / no-op at accept, or for search at walk end
    always_comb begin
        fin_next     = '0;
        fin_next.cnt = count_reg;
        if (state_reg == htsr_pkg::ST_IDLE) begin
            if (s_tuser == htsr_pkg::REQ_ADD) begin
                if (count_reg >= htsr_pkg::CNT_W'(CAP)) begin
                    fin_next.full = 1'b1;
                end else begin
                    fin_next.found   = 1'b1;
                    fin_next.slot    = count_reg[htsr_pkg::IDX_W-1:0];
                    fin_next.cnt     = count_reg + htsr_pkg::CNT_W'(1);
                    fin_next.wr.en   = 1'b1;
                    fin_next.wr.slot = count_reg[htsr_pkg::IDX_W-1:0];
                    fin_next.wr.data = req_handle;
                end
            end
        end else if (tok_end.hit) begin
            fin_next.found = 1'b1;
            fin_next.slot  = tok_end.slot;
            if (tok_end.del) begin
                fin_next.cnt     = count_reg - htsr_pkg::CNT_W'(1);
                fin_next.wr.en   = 1'b1;
                fin_next.wr.slot = tok_end.slot;
                fin_next.wr.data = tok_end.last;
            end
        end
    end

    always_comb begin
        wr    = fin_reg.wr;
        wr.en = commit && fin_reg.wr.en;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= htsr_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                count_reg   <= fin_reg.cnt;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_load) begin
            fin_reg <= fin_next;
        end
        if (commit) begin
            m_res_reg <= fin_reg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAP; i++) begin : g_cell
            htsr_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (htsr_pkg::IDX_W'(i)),
                .count    (count_reg),
                .wr       (wr),
                .tok_in   (tok[i]),
                .tok_out  (tok[i+1])
            );
        end
    endgenerate

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0,
                       htsr_pkg::COUNT_W_OUT'(m_res_reg.cnt),
                       htsr_pkg::SLOT_W'(m_res_reg.slot)};
    assign m_tuser  = {m_res_reg.full, m_res_reg.found};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= htsr_pkg::CNT_W'(CAP))
        else $error("entry count above capacity");

    a_token_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_end.active |-> state_reg == htsr_pkg::ST_WALK)
        else $error("search token out of walk state");

    a_commit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> count_reg == $past(fin_reg.cnt))
        else $error("count not updated on commit");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_res_reg.found && m_res_reg.full))
        else $error("found and table_full both set");

endmodule

// ----- design/htsr_cell.sv -----
// One table cell: holds a single entry, compares it against the passing
// search token and hands the token on. Depends on htsr_pkg.
module htsr_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [htsr_pkg::IDX_W-1:0]      cell_idx,
    input  logic [htsr_pkg::CNT_W-1:0]      count,
    input  htsr_pkg::wr_t                   wr,
    input  htsr_pkg::token_t                tok_in,
    output htsr_pkg::token_t                tok_out
);

    logic [htsr_pkg::HANDLE_BITS-1:0] entry_reg;
    htsr_pkg::token_t                 tok_reg;
    htsr_pkg::token_t                 tok_next;
    logic                             in_use;
    logic                             is_last;

    always_comb begin
        in_use   = htsr_pkg::CNT_W'(cell_idx) < count;
        is_last  = (htsr_pkg::CNT_W'(cell_idx) + htsr_pkg::CNT_W'(1)) == count;
        tok_next = tok_in;
        if (tok_in.active && in_use && !tok_in.hit && entry_reg == tok_in.handle) begin
            tok_next.hit  = 1'b1;
            tok_next.slot = cell_idx;
        end
        if (tok_in.active && is_last) begin
            tok_next.last = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && wr.slot == cell_idx) begin
            entry_reg <= wr.data;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- sim/handle_table_swap_remove_top_tb.sv -----
// Self-checking testbench for handle_table_swap_remove_top: a directed table,
// then random add/find/delete traffic with bursty sender and stalling receiver.
// Depends on htsr_pkg and the design under design/.
module handle_table_swap_remove_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_ADD    = htsr_pkg::REQ_ADD;
    localparam logic [1:0] REQ_FIND   = htsr_pkg::REQ_FIND;
    localparam logic [1:0] REQ_DELETE = htsr_pkg::REQ_DELETE;
    localparam logic [1:0] REQ_NOP = 2'd3;   // unused request code
    localparam int N_RANDOM  = 2000;
    localparam int POOL_SIZE = 12;
    localparam int IDLE_LIMIT = 1000;

    typedef struct packed {
        logic       found;
        logic [3:0] slot;
        logic [4:0] entry_count;
        logic       table_full;
    } reply_t;

    typedef struct {
        logic [1:0]  req;
        logic [47:0] handle;
        int          reps;
        bit          typed;
        reply_t      want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    // shadow copy of the table
    logic [htsr_pkg::HANDLE_BITS-1:0] shadow_entries [htsr_pkg::CAPACITY];
    int                               shadow_count;

    reply_t      pending_replies [$];
    logic [47:0] handle_pool [POOL_SIZE];
    dir_row_t    dir_rows [18];
    int          err_cnt, words_seen, n_hits, n_refused, n_items;
    int          burst_left, idle_cycles;
    int          rx_tick, rx_mode, rx_stall;

    handle_table_swap_remove_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // apply one request to the shadow table and return the reply it yields
    function automatic reply_t apply_request(logic [1:0] req, logic [47:0] h);
        reply_t                           r;
        int                               hit_idx;
        logic [htsr_pkg::HANDLE_BITS-1:0] hm;
        r = '0;
        hit_idx = -1;
        hm = h[htsr_pkg::HANDLE_BITS-1:0];
        case (req)
            REQ_ADD: begin
                if (shadow_count >= htsr_pkg::CAPACITY) begin
                    r.table_full = 1'b1;
                    n_refused++;
                end else begin
                    shadow_entries[shadow_count] = hm;
                    r.found = 1'b1;
                    r.slot = shadow_count[3:0];
                    shadow_count++;
                end
            end
            REQ_FIND, REQ_DELETE: begin
                for (int i = 0; i < shadow_count; i++)
                    if (hit_idx < 0 && shadow_entries[i] == hm) hit_idx = i;
                if (hit_idx >= 0) begin
                    r.found = 1'b1;
                    r.slot = hit_idx[3:0];
                    n_hits++;
                    if (req == REQ_DELETE) begin
                        shadow_count--;
                        shadow_entries[hit_idx] = shadow_entries[shadow_count];
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = shadow_count[4:0];
        return r;
    endfunction

    // drive one word, wait for acceptance, then gap or drain as asked
    task automatic issue(input logic [1:0] req, input logic [47:0] h,
                         input bit typed, input reply_t want, input bit hold);
        reply_t predicted;
        s_tuser  <= req;
        s_tdata  <= h;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_request(req, h);
        pending_replies.push_back(typed ? want : predicted);
        n_items++;
        @(negedge aclk);
        if (hold || burst_left == 0) begin
            s_tvalid <= 1'b0;
            if (hold)
                while (pending_replies.size() != 0) @(negedge aclk);
            repeat ($urandom_range(1, 20)) @(negedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
        end else begin
            burst_left--;
        end
    endtask

    // receiver: picks at random between always-ready, random-ready and stall modes
    always @(negedge aclk) begin
        rx_tick++;
        if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 2);
        if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        rx_stall = $urandom_range(1, 25);
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        reply_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (pending_replies.size() == 0) begin
                $error("result word with no request pending");
                err_cnt++;
            end else begin
                exp_r = pending_replies.pop_front();
                if (m_tuser[0] !== exp_r.found) begin
                    $error("found: expected %0d, got %0d", exp_r.found, m_tuser[0]);
                    err_cnt++;
                end
                if (m_tdata[3:0] !== exp_r.slot) begin
                    $error("slot: expected %0d, got %0d", exp_r.slot, m_tdata[3:0]);
                    err_cnt++;
                end
                if (m_tdata[8:4] !== exp_r.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_r.entry_count, m_tdata[8:4]);
                    err_cnt++;
                end
                if (m_tuser[1] !== exp_r.table_full) begin
                    $error("table_full: expected %0d, got %0d",
                           exp_r.table_full, m_tuser[1]);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [63:0] rnd;
        logic [47:0] h;
        logic [1:0]  req;
        int          pick;
        bit          del_phase;

        dir_rows = '{
            '{REQ_FIND,   48'h0,              1,  1'b1, '{1'b0, 4'd0, 5'd0,  1'b0}},
            '{REQ_DELETE, 48'h5,              1,  1'b1, '{1'b0, 4'd0, 5'd0,  1'b0}},
            '{REQ_NOP,    48'hFFFF_FFFF_FFFF, 1,  1'b1, '{1'b0, 4'd0, 5'd0,  1'b0}},
            '{REQ_ADD,    48'hFFFF_FFFF_FFFF, 1,  1'b1, '{1'b1, 4'd0, 5'd1,  1'b0}},
            '{REQ_ADD,    48'h0,              1,  1'b1, '{1'b1, 4'd1, 5'd2,  1'b0}},
            '{REQ_ADD,    48'h0,              1,  1'b1, '{1'b1, 4'd2, 5'd3,  1'b0}},
            '{REQ_FIND,   48'h0,              1,  1'b1, '{1'b1, 4'd1, 5'd3,  1'b0}},
            '{REQ_FIND,   48'hFFFF_FFFF_FFFF, 1,  1'b1, '{1'b1, 4'd0, 5'd3,  1'b0}},
            '{REQ_DELETE, 48'hFFFF_FFFF_FFFF, 1,  1'b1, '{1'b1, 4'd0, 5'd2,  1'b0}},
            '{REQ_ADD,    48'h5555_5555_5555, 1,  1'b0, '0},
            '{REQ_ADD,    48'hAAAA_AAAA_AAAA, 1,  1'b0, '0},
            '{REQ_ADD,    48'h0000_0000_1000, 12, 1'b0, '0},
            '{REQ_ADD,    48'h0000_0000_0123, 1,  1'b1, '{1'b0, 4'd0, 5'd16, 1'b1}},
            '{REQ_NOP,    48'h0,              1,  1'b1, '{1'b0, 4'd0, 5'd16, 1'b0}},
            '{REQ_FIND,   48'h0000_0000_100B, 1,  1'b0, '0},
            '{REQ_DELETE, 48'h5555_5555_5555, 1,  1'b0, '0},
            '{REQ_DELETE, 48'h0,              1,  1'b0, '0},
            '{REQ_FIND,   48'h0,              1,  1'b0, '0}
        };

        shadow_count = 0;
        foreach (shadow_entries[i]) shadow_entries[i] = '0;
        handle_pool[0] = '0;
        handle_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            rnd = {$urandom, $urandom};
            handle_pool[i] = rnd[47:0];
        end
        burst_left = $urandom_range(1, 30);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[r])
            for (int k = 0; k < dir_rows[r].reps; k++)
                issue(dir_rows[r].req, dir_rows[r].handle + 48'(k), dir_rows[r].typed,
                      dir_rows[r].want, r == $size(dir_rows) - 1);

        for (int n = 0; n < N_RANDOM; n++) begin
            // alternate fill-heavy and drain-heavy phases so count sweeps 0..16
            del_phase = ((n / 150) % 2) != 0;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                req = REQ_NOP;
            else if (pick < (del_phase ? 25 : 50))
                req = REQ_ADD;
            else if (pick < (del_phase ? 50 : 75))
                req = REQ_FIND;
            else
                req = REQ_DELETE;
            pick = $urandom_range(0, 99);
            rnd = {$urandom, $urandom};
            if (pick < 50 && shadow_count > 0)
                h = 48'(shadow_entries[$urandom_range(0, shadow_count - 1)]);
            else if (pick < 80)
                h = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                h = rnd[47:0];
            issue(req, h, 1'b0, '0, n == N_RANDOM / 2 || n == N_RANDOM - 1);
        end

        repeat (40) @(posedge aclk);
        $display("%0d requests sent, %0d words checked: %0d find/delete hits, %0d adds refused",
                 n_items, words_seen, n_hits, n_refused);
        if (err_cnt == 0 && pending_replies.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
